@@ src/oqkr_pkg.sv @@
// Package with the shared codes and key width of the ordered queue with keyed remove.
package oqkr_pkg;

  localparam int unsigned KEY_W = 64;

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_SEARCH = 2'd1,
    OP_REMOVE = 2'd2,
    OP_POP    = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_EMPTY     = 2'd3
  } status_e;

endpackage

@@ src/oqkr_mem.sv @@
// Simple dual-port key memory with one write port and one registered read port.
module oqkr_mem
  import oqkr_pkg::*;
#(
  parameter int unsigned DEPTH  = 64,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              wr_en_i,
  input  logic [ADDR_W-1:0] wr_addr_i,
  input  logic [KEY_W-1:0]  wr_data_i,
  input  logic              rd_en_i,
  input  logic [ADDR_W-1:0] rd_addr_i,
  output logic [KEY_W-1:0]  rd_data_o
);

  logic [KEY_W-1:0] mem_q [DEPTH];
  logic [KEY_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ src/ordered_queue_keyed_remove.sv @@
// Top level of the ordered key queue with append, search, keyed remove and pop.
//
// Usage: each input word on the slave channel carries an operation in s_tuser_i
// and a 64-bit key in s_tdata_i. Every input word yields exactly one output word
// on the master channel: the status in m_tuser_o and the popped head in
// m_tdata_o, which is zero for all other operations and for a pop of an empty
// queue. The keys live in one memory used as a ring, with a head pointer and a
// fill count in flip-flops.
// Timing: one operation is processed at a time. Append writes the key at
// acceptance and goes on to the output register; pop first reads the head from
// memory. Search scans one entry per cycle through the memory read port. Remove
// scans the same way and then moves every later entry down one slot, one entry
// per cycle through the read and write ports. The next word can be accepted in
// the cycle after the result is loaded.
// Reset empties the queue; memory contents are not cleared and need no pass.
// A finished result waits in the output register while the next word is
// accepted; if the receiver stalls, the block holds its next result, and
// accepts no new word, until the output register is free.
module ordered_queue_keyed_remove
  import oqkr_pkg::*;
#(
  parameter int unsigned CAPACITY = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_tvalid_i,
  output logic             s_tready_o,
  input  logic [KEY_W-1:0] s_tdata_i,   // [63:0] key
  input  logic [1:0]       s_tuser_i,   // [1:0] operation
  output logic             m_tvalid_o,
  input  logic             m_tready_i,
  output logic [KEY_W-1:0] m_tdata_o,   // [63:0] head_value
  output logic [1:0]       m_tuser_o    // [1:0] status
);

  localparam int unsigned PTR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_POP_WAIT,
    S_SCAN,
    S_SHIFT,
    S_FINISH
  } state_e;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    logic [PTR_W:0] s;
    s = {1'b0, p} + (PTR_W+1)'(1);
    if (s == (PTR_W+1)'(CAPACITY)) begin
      return '0;
    end
    return s[PTR_W-1:0];
  endfunction

  state_e           state_q, state_d;
  logic [PTR_W-1:0] head_q, head_d;
  logic [CNT_W-1:0] count_q, count_d;
  op_e              op_q, op_d;
  logic [KEY_W-1:0] key_q, key_d;
  status_e          res_status_q, res_status_d;
  logic [KEY_W-1:0] res_head_q, res_head_d;
  logic [CNT_W-1:0] rd_idx_q, rd_idx_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic             cmp_v_q, cmp_v_d;
  logic [CNT_W-1:0] cmp_idx_q, cmp_idx_d;
  logic [PTR_W-1:0] cmp_ptr_q, cmp_ptr_d;
  logic [PTR_W-1:0] dst_ptr_q, dst_ptr_d;
  logic             m_valid_q, m_valid_d;
  status_e          m_status_q, m_status_d;
  logic [KEY_W-1:0] m_head_q, m_head_d;

  logic             wr_en;
  logic [PTR_W-1:0] wr_addr;
  logic [KEY_W-1:0] wr_data;
  logic             rd_en;
  logic [PTR_W-1:0] rd_addr;
  logic [KEY_W-1:0] rd_data;

  logic [PTR_W:0]   tail_sum;
  logic [PTR_W-1:0] tail_ptr;
  logic             rd_more;
  logic             hit;
  logic             last;

  oqkr_mem #(
    .DEPTH (CAPACITY),
    .ADDR_W(PTR_W)
  ) u_mem (
    .clk_i    (clk_i),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_data),
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data)
  );

  always_comb begin
    tail_sum = {1'b0, head_q} + (PTR_W+1)'(count_q);
    if (tail_sum >= (PTR_W+1)'(CAPACITY)) begin
      tail_sum = tail_sum - (PTR_W+1)'(CAPACITY);
    end
    tail_ptr = tail_sum[PTR_W-1:0];
  end

  assign rd_more = (rd_idx_q < count_q);
  assign hit     = cmp_v_q && (rd_data == key_q);
  assign last    = cmp_v_q && (cmp_idx_q == (count_q - CNT_W'(1)));

  assign s_tready_o = (state_q == S_IDLE);
  assign m_tvalid_o = m_valid_q;
  assign m_tdata_o  = m_head_q;
  assign m_tuser_o  = m_status_q;

  always_comb begin
    state_d      = state_q;
    head_d       = head_q;
    count_d      = count_q;
    op_d         = op_q;
    key_d        = key_q;
    res_status_d = res_status_q;
    res_head_d   = res_head_q;
    rd_idx_d     = rd_idx_q;
    rd_ptr_d     = rd_ptr_q;
    cmp_v_d      = cmp_v_q;
    cmp_idx_d    = cmp_idx_q;
    cmp_ptr_d    = cmp_ptr_q;
    dst_ptr_d    = dst_ptr_q;
    m_valid_d    = m_valid_q;
    m_status_d   = m_status_q;
    m_head_d     = m_head_q;
    wr_en        = 1'b0;
    wr_addr      = tail_ptr;
    wr_data      = s_tdata_i;
    rd_en        = 1'b0;
    rd_addr      = rd_ptr_q;

    if (m_valid_q && m_tready_i) begin
      m_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (s_tvalid_i) begin
          op_d         = op_e'(s_tuser_i);
          key_d        = s_tdata_i;
          res_head_d   = '0;
          res_status_d = ST_OK;
          rd_idx_d     = '0;
          rd_ptr_d     = head_q;
          cmp_v_d      = 1'b0;
          state_d      = S_FINISH;
          case (op_e'(s_tuser_i))
            OP_APPEND: begin
              if (count_q == CNT_W'(CAPACITY)) begin
                res_status_d = ST_FULL;
              end else begin
                wr_en   = 1'b1;
                count_d = count_q + CNT_W'(1);
              end
            end
            OP_SEARCH, OP_REMOVE: begin
              if (count_q == '0) begin
                res_status_d = ST_NOT_FOUND;
              end else begin
                state_d = S_SCAN;
              end
            end
            OP_POP: begin
              if (count_q == '0) begin
                res_status_d = ST_EMPTY;
              end else begin
                rd_en   = 1'b1;
                rd_addr = head_q;
                state_d = S_POP_WAIT;
              end
            end
            default: begin
              state_d = S_FINISH;
            end
          endcase
        end
      end
      S_POP_WAIT: begin
        res_head_d = rd_data;
        head_d     = ptr_inc(head_q);
        count_d    = count_q - CNT_W'(1);
        state_d    = S_FINISH;
      end
      S_SCAN: begin
        if (hit) begin
          cmp_v_d = 1'b0;
          if (op_q == OP_SEARCH) begin
            res_status_d = ST_OK;
            state_d      = S_FINISH;
          end else begin
            rd_idx_d  = cmp_idx_q + CNT_W'(1);
            rd_ptr_d  = ptr_inc(cmp_ptr_q);
            dst_ptr_d = cmp_ptr_q;
            state_d   = S_SHIFT;
          end
        end else if (last) begin
          cmp_v_d      = 1'b0;
          res_status_d = ST_NOT_FOUND;
          state_d      = S_FINISH;
        end else if (rd_more) begin
          rd_en     = 1'b1;
          cmp_v_d   = 1'b1;
          cmp_idx_d = rd_idx_q;
          cmp_ptr_d = rd_ptr_q;
          rd_idx_d  = rd_idx_q + CNT_W'(1);
          rd_ptr_d  = ptr_inc(rd_ptr_q);
        end else begin
          cmp_v_d = 1'b0;
        end
      end
      S_SHIFT: begin
        if (cmp_v_q) begin
          wr_en     = 1'b1;
          wr_addr   = dst_ptr_q;
          wr_data   = rd_data;
          dst_ptr_d = ptr_inc(dst_ptr_q);
        end
        if (rd_more) begin
          rd_en    = 1'b1;
          cmp_v_d  = 1'b1;
          rd_idx_d = rd_idx_q + CNT_W'(1);
          rd_ptr_d = ptr_inc(rd_ptr_q);
        end else begin
          cmp_v_d = 1'b0;
          if (!cmp_v_q) begin
            count_d      = count_q - CNT_W'(1);
            res_status_d = ST_OK;
            state_d      = S_FINISH;
          end
        end
      end
      S_FINISH: begin
        if (!m_valid_q || m_tready_i) begin
          m_valid_d  = 1'b1;
          m_status_d = res_status_q;
          m_head_d   = res_head_q;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      head_q    <= '0;
      count_q   <= '0;
      cmp_v_q   <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      head_q    <= head_d;
      count_q   <= count_d;
      cmp_v_q   <= cmp_v_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    key_q        <= key_d;
    res_status_q <= res_status_d;
    res_head_q   <= res_head_d;
    rd_idx_q     <= rd_idx_d;
    rd_ptr_q     <= rd_ptr_d;
    cmp_idx_q    <= cmp_idx_d;
    cmp_ptr_q    <= cmp_ptr_d;
    dst_ptr_q    <= dst_ptr_d;
    m_status_q   <= m_status_d;
    m_head_q     <= m_head_d;
  end

endmodule

@@ tb/sv/tb_ordered_queue_keyed_remove.sv @@
// Self-checking testbench for the ordered key queue with search, keyed remove and pop.
module tb_ordered_queue_keyed_remove;
  import oqkr_pkg::*;

  localparam int unsigned CAPACITY = 64;
  localparam int RANDOM_WORDS = 500;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic [KEY_W-1:0] ALL_ONES = {KEY_W{1'b1}};

  typedef struct packed {
    status_e          status;
    logic [KEY_W-1:0] head;
  } queue_result_t;

  typedef struct packed {
    op_e              op;
    logic [KEY_W-1:0] key;
    bit               typed;
    queue_result_t    res;
  } stim_row_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             s_tvalid_i = 1'b0;
  logic             s_tready_o;
  logic [KEY_W-1:0] s_tdata_i = '0;   // [63:0] key
  logic [1:0]       s_tuser_i = '0;   // [1:0] operation
  logic             m_tvalid_o;
  logic             m_tready_i = 1'b0;
  logic [KEY_W-1:0] m_tdata_o;        // [63:0] head_value
  logic [1:0]       m_tuser_o;        // [1:0] status

  logic [KEY_W-1:0] held_keys[$];
  queue_result_t    pending_results[$];
  queue_result_t    oldest_result;
  bit               calm = 1'b0;
  int               mismatch_count = 0;
  int               cycle_count = 0;
  int               op_count[4] = '{0, 0, 0, 0};
  int               status_seen[4] = '{0, 0, 0, 0};

  // Typed rows carry an expectation that is obvious from the queue contents.
  stim_row_t directed_rows[19] = '{
    '{OP_POP,    64'd0,                 1'b1, '{ST_EMPTY,     64'd0}},
    '{OP_SEARCH, 64'd0,                 1'b1, '{ST_NOT_FOUND, 64'd0}},
    '{OP_REMOVE, ALL_ONES,              1'b1, '{ST_NOT_FOUND, 64'd0}},
    '{OP_APPEND, 64'd0,                 1'b1, '{ST_OK,        64'd0}},
    '{OP_APPEND, ALL_ONES,              1'b1, '{ST_OK,        64'd0}},
    '{OP_APPEND, 64'h5555_5555_5555_5555, 1'b1, '{ST_OK,      64'd0}},
    '{OP_APPEND, 64'd0,                 1'b1, '{ST_OK,        64'd0}},
    '{OP_APPEND, 64'h8000_0000_0000_0001, 1'b0, '{ST_OK,      64'd0}},
    '{OP_SEARCH, ALL_ONES,              1'b0, '{ST_OK,        64'd0}},
    '{OP_SEARCH, 64'd1,                 1'b0, '{ST_OK,        64'd0}},
    '{OP_REMOVE, 64'd0,                 1'b0, '{ST_OK,        64'd0}},
    '{OP_SEARCH, 64'd0,                 1'b0, '{ST_OK,        64'd0}},
    '{OP_REMOVE, 64'h8000_0000_0000_0001, 1'b0, '{ST_OK,      64'd0}},
    '{OP_POP,    ALL_ONES,              1'b0, '{ST_OK,        64'd0}},
    '{OP_REMOVE, 64'd0,                 1'b0, '{ST_OK,        64'd0}},
    '{OP_REMOVE, 64'd0,                 1'b0, '{ST_OK,        64'd0}},
    '{OP_POP,    64'd0,                 1'b0, '{ST_OK,        64'd0}},
    '{OP_POP,    64'h5555_5555_5555_5555, 1'b1, '{ST_EMPTY,   64'd0}},
    '{OP_APPEND, 64'hAAAA_AAAA_AAAA_AAAA, 1'b1, '{ST_OK,      64'd0}}
  };

  ordered_queue_keyed_remove #(
    .CAPACITY(CAPACITY)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .s_tdata_i  (s_tdata_i),
    .s_tuser_i  (s_tuser_i),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o),
    .m_tuser_o  (m_tuser_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic queue_result_t predict_queue_op(op_e op, logic [KEY_W-1:0] key);
    queue_result_t r;
    int pos;
    r.status = ST_OK;
    r.head = '0;
    pos = -1;
    case (op)
      OP_APPEND: begin
        if (held_keys.size() >= CAPACITY) r.status = ST_FULL;
        else held_keys.push_back(key);
      end
      OP_SEARCH, OP_REMOVE: begin
        foreach (held_keys[i]) if (pos < 0 && held_keys[i] == key) pos = i;
        if (pos < 0) r.status = ST_NOT_FOUND;
        else if (op == OP_REMOVE) held_keys.delete(pos);
      end
      default: begin
        if (held_keys.size() == 0) r.status = ST_EMPTY;
        else r.head = held_keys.pop_front();
      end
    endcase
    return r;
  endfunction

  function automatic logic [KEY_W-1:0] pick_key(op_e op);
    logic [KEY_W-1:0] k;
    int sel;
    k = {$urandom, $urandom};
    sel = $urandom_range(9);
    if ((op == OP_SEARCH || op == OP_REMOVE) && held_keys.size() != 0 && sel < 6)
      k = held_keys[$urandom_range(held_keys.size() - 1)];
    else if (sel >= 6)
      k = (sel == 9) ? ALL_ONES : KEY_W'($urandom_range(7));
    return k;
  endfunction

  task automatic report_mismatch(string what, logic [KEY_W-1:0] got, logic [KEY_W-1:0] want);
    $display("MISMATCH at %0t: %s got %h want %h", $time, what, got, want);
    mismatch_count++;
  endtask

  task automatic send_word(op_e op, logic [KEY_W-1:0] key, bit typed, queue_result_t typed_res);
    queue_result_t predicted;
    int gap;
    gap = (!calm && $urandom_range(99) < 10) ? $urandom_range(3, 1) : 0;
    if (gap != 0) begin
      s_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid_i <= 1'b1;
    s_tuser_i  <= op;
    s_tdata_i  <= key;
    @(posedge clk_i);
    while (!s_tready_o) @(posedge clk_i);
    predicted = predict_queue_op(op, key);
    pending_results.push_back(typed ? typed_res : predicted);
    op_count[op]++;
  endtask

  always @(posedge clk_i) begin
    m_tready_i <= calm || ($urandom_range(99) >= 10);
  end

  always @(posedge clk_i) begin
    if (m_tvalid_o && m_tready_i) begin
      status_seen[m_tuser_o]++;
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing expected, data", m_tdata_o, '0);
      end else begin
        oldest_result = pending_results.pop_front();
        if (m_tuser_o !== oldest_result.status)
          report_mismatch("status", KEY_W'(m_tuser_o), KEY_W'(oldest_result.status));
        if (m_tdata_o !== oldest_result.head)
          report_mismatch("head value", m_tdata_o, oldest_result.head);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding.", cycle_count,
               pending_results.size());
      $display("ordered_queue_keyed_remove test failed");
      $finish;
    end
  end

  initial begin
    int roll;
    int append_lim;
    int search_lim;
    int remove_lim;
    op_e op;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i])
      send_word(directed_rows[i].op, directed_rows[i].key, directed_rows[i].typed,
                directed_rows[i].res);

    // Fill until the queue overflows, churn, run without stalls, drain past empty, churn.
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      calm = (n >= 200 && n < 300);
      if (n < 120) begin
        append_lim = 85; search_lim = 90; remove_lim = 95;
      end else if (n >= 300 && n < 400) begin
        append_lim = 5;  search_lim = 15; remove_lim = 25;
      end else begin
        append_lim = 35; search_lim = 55; remove_lim = 80;
      end
      roll = $urandom_range(99);
      op = (roll < append_lim) ? OP_APPEND :
           (roll < search_lim) ? OP_SEARCH :
           (roll < remove_lim) ? OP_REMOVE : OP_POP;
      send_word(op, pick_key(op), 1'b0, '0);
    end
    calm = 1'b0;
    s_tvalid_i <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);

    $display("Run covered %0d words: %0d append, %0d search, %0d remove, %0d pop.",
             op_count[0] + op_count[1] + op_count[2] + op_count[3],
             op_count[OP_APPEND], op_count[OP_SEARCH], op_count[OP_REMOVE], op_count[OP_POP]);
    $display("Statuses seen: %0d ok, %0d not found, %0d full, %0d empty; %0d mismatches.",
             status_seen[ST_OK], status_seen[ST_NOT_FOUND], status_seen[ST_FULL],
             status_seen[ST_EMPTY], mismatch_count);
    if (mismatch_count == 0) begin
      $display("ordered_queue_keyed_remove test passed");
    end else begin
      $display("ordered_queue_keyed_remove test failed");
    end
    $finish;
  end

endmodule
